FILE: rtl/two_class_priority_queue_core_macros.svh
// Assertion macros shared by the two-class priority queue RTL.
`ifndef TWO_CLASS_PRIORITY_QUEUE_CORE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPQ_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcpq_pkg.sv
// Types, codes and default sizes of the two-class priority queue.
`default_nettype none
package tcpq_pkg;

    localparam int unsigned DEPTH_DEF    = 16;
    localparam int unsigned TAG_BITS_DEF = 32;

    typedef logic [2:0] t_status;

    localparam logic     KIND_ARRIVE = 1'b0;
    localparam logic     KIND_SERVE  = 1'b1;

    localparam logic [1:0] CLASS_HIGH = 2'd1;
    localparam logic [1:0] CLASS_LOW  = 2'd2;

    localparam t_status ST_ACCEPTED = 3'd0;
    localparam t_status ST_SERVED   = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_INVALID  = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [1:0]  class_code;
        logic [31:0] entry_tag;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] served_tag;
        logic        served_class;
    } t_out_item;

endpackage
`default_nettype wire

FILE: rtl/tcpq_stream_if.sv
// Valid/ready stream channel that carries one item per handshake.
`default_nettype none
interface tcpq_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/tcpq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module tcpq_ram #(
    parameter int unsigned WIDTH = tcpq_pkg::TAG_BITS_DEF,
    parameter int unsigned DEPTH = tcpq_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Read data holds until the next read, so a stalled item keeps its tag.
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/two_class_priority_queue_core.sv
// Two-class strict-priority queue: one high and one low FIFO, each DEPTH entries deep,
// with every input item answered by exactly one result item. An arrive item stores its
// tag in the FIFO of its class (or reports full or invalid class); a serve item pops the
// high FIFO first and the low FIFO only when the high one is empty. The block takes one
// item per clock cycle while its result register is empty or being taken, and returns its
// result in the cycle after acceptance; the head and count registers are updated at
// acceptance and the tag comes from the registered read port of the selected FIFO RAM.
`default_nettype none
`include "two_class_priority_queue_core_macros.svh"
module two_class_priority_queue_core #(
    parameter int unsigned DEPTH    = tcpq_pkg::DEPTH_DEF,
    parameter int unsigned TAG_BITS = tcpq_pkg::TAG_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tcpq_stream_if.sink   i_in,
    tcpq_stream_if.source o_out
);
    import tcpq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_high_head, n_high_head;
    logic [CW-1:0] r_high_count, n_high_count;
    logic [AW-1:0] r_low_head, n_low_head;
    logic [CW-1:0] r_low_count, n_low_count;

    logic    r_valid, n_valid;
    t_status r_status, n_status;
    logic    r_from_low, n_from_low;

    logic          w_accept;
    logic          w_high_empty, w_low_empty, w_high_full, w_low_full;
    logic          w_push_high, w_push_low, w_pop_high, w_pop_low;
    logic [AW-1:0] w_high_tail, w_low_tail;
    logic [TAG_BITS-1:0] w_wr_tag, w_high_rd, w_low_rd;

    // Tail slot: head plus count, wrapped once since the sum stays below 2 * DEPTH.
    function automatic logic [AW-1:0] tail_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] count);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(count);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] next_head(input logic [AW-1:0] head);
        return (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    endfunction

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_high_empty = (r_high_count == '0);
    assign w_low_empty  = (r_low_count == '0);
    assign w_high_full  = (r_high_count == CW'(DEPTH));
    assign w_low_full   = (r_low_count == CW'(DEPTH));

    assign w_push_high = w_accept && (i_in.payload.kind == KIND_ARRIVE)
                         && (i_in.payload.class_code == CLASS_HIGH) && !w_high_full;
    assign w_push_low  = w_accept && (i_in.payload.kind == KIND_ARRIVE)
                         && (i_in.payload.class_code == CLASS_LOW) && !w_low_full;
    assign w_pop_high  = w_accept && (i_in.payload.kind == KIND_SERVE) && !w_high_empty;
    assign w_pop_low   = w_accept && (i_in.payload.kind == KIND_SERVE) && w_high_empty
                         && !w_low_empty;

    assign w_high_tail = tail_of(r_high_head, r_high_count);
    assign w_low_tail  = tail_of(r_low_head, r_low_count);
    assign w_wr_tag    = TAG_BITS'(i_in.payload.entry_tag);

    // Only one item enters per cycle, so a write and a read never meet in one FIFO.
    tcpq_ram #(.WIDTH(TAG_BITS), .DEPTH(DEPTH)) u_high_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push_high),
        .i_wr_addr (w_high_tail),
        .i_wr_data (w_wr_tag),
        .i_rd_en   (w_pop_high),
        .i_rd_addr (r_high_head),
        .o_rd_data (w_high_rd)
    );

    tcpq_ram #(.WIDTH(TAG_BITS), .DEPTH(DEPTH)) u_low_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push_low),
        .i_wr_addr (w_low_tail),
        .i_wr_data (w_wr_tag),
        .i_rd_en   (w_pop_low),
        .i_rd_addr (r_low_head),
        .o_rd_data (w_low_rd)
    );

    always_comb begin
        n_high_head  = r_high_head;
        n_high_count = r_high_count;
        n_low_head   = r_low_head;
        n_low_count  = r_low_count;
        n_valid      = r_valid;
        n_status     = r_status;
        n_from_low   = r_from_low;

        if (o_out.ready) begin
            n_valid = 1'b0;
        end

        if (w_push_high) begin
            n_high_count = r_high_count + 1'b1;
        end
        if (w_push_low) begin
            n_low_count = r_low_count + 1'b1;
        end
        if (w_pop_high) begin
            n_high_head  = next_head(r_high_head);
            n_high_count = r_high_count - 1'b1;
        end
        if (w_pop_low) begin
            n_low_head  = next_head(r_low_head);
            n_low_count = r_low_count - 1'b1;
        end

        if (w_accept) begin
            n_valid    = 1'b1;
            n_from_low = w_pop_low;
            if (i_in.payload.kind == KIND_SERVE) begin
                n_status = (w_pop_high || w_pop_low) ? ST_SERVED : ST_EMPTY;
            end else begin
                case (i_in.payload.class_code)
                    CLASS_HIGH: n_status = w_high_full ? ST_FULL : ST_ACCEPTED;
                    CLASS_LOW:  n_status = w_low_full ? ST_FULL : ST_ACCEPTED;
                    default:    n_status = ST_INVALID;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_head  <= '0;
            r_high_count <= '0;
            r_low_head   <= '0;
            r_low_count  <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_high_head  <= n_high_head;
            r_high_count <= n_high_count;
            r_low_head   <= n_low_head;
            r_low_count  <= n_low_count;
            r_valid      <= n_valid;
        end
        r_status   <= n_status;
        r_from_low <= n_from_low;
    end

    assign o_out.valid                = r_valid;
    assign o_out.payload.status       = r_status;
    assign o_out.payload.served_class = (r_status == ST_SERVED) ? r_from_low : 1'b0;
    assign o_out.payload.served_tag   = (r_status != ST_SERVED) ? 32'd0 :
                                        r_from_low ? 32'(w_low_rd) : 32'(w_high_rd);

    `TCPQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        (r_high_count <= CW'(DEPTH)) && (r_low_count <= CW'(DEPTH)),
        "FIFO count exceeds its depth")

    `TCPQ_ASSERT_NEXT(a_high_pop_count, i_clk, i_rst_n, w_pop_high,
        r_high_count == $past(r_high_count) - 1'b1,
        "High FIFO count did not drop after a serve")

    `TCPQ_ASSERT_NEXT(a_low_only_when_high_empty, i_clk, i_rst_n, w_pop_low,
        (r_high_count == '0) && r_from_low && (r_status == ST_SERVED),
        "Low FIFO served while the high FIFO held entries")

    `TCPQ_ASSERT_SAME(a_single_fifo_op, i_clk, i_rst_n, w_accept,
        $countones({w_push_high, w_push_low, w_pop_high, w_pop_low}) <= 1,
        "More than one FIFO touched by one item")
endmodule
`default_nettype wire
